### rtl/core/set_assoc_lru_cache_model_macros.svh
// Assertion macros for the cache model block.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_MACROS_SVH
`ifndef SYNTH
`define SALC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SALC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SALC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SALC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/salc_pkg.sv
package salc_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_READ  = 2'd0;
	localparam action_t ACT_WRITE = 2'd1;
	localparam action_t ACT_FETCH = 2'd2;
	localparam action_t ACT_FLUSH = 2'd3;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SPLIT = 3'd0;
	localparam cfg_idx_t CFG_DSETS = 3'd1;
	localparam cfg_idx_t CFG_ISETS = 3'd2;
	localparam cfg_idx_t CFG_WAYS  = 3'd3;
	localparam cfg_idx_t CFG_BOFF  = 3'd4;
	localparam cfg_idx_t CFG_WB    = 3'd5;
	localparam cfg_idx_t CFG_WA    = 3'd6;

	localparam int CFG_W = 4;

	localparam logic [3:0] BOFF_MIN = 4'd2;
	localparam logic [3:0] BOFF_MAX = 4'd12;

endpackage

### rtl/core/set_assoc_lru_cache_model.sv
// Channel    | Ports                                   | Transfer
// command    | start, busy, action, address            | start && !busy
// result     | done, hit, side, access_count,          | done (one cycle, no stall)
//            | miss_count, replace_count, fetch_words, |
//            | copyback_words                          |
// config     | wr_en, wr_index, wr_data                | wr_en
//
// Read, write or fetch: one tag-row read and, unless a write misses with write-allocate
// off, one row write-back on the data or instruction memory. Flush walks all
// 2^floor(log2 MAX_SETS) rows of the data memory, one row a cycle. After reset a clearing
// pass over all those rows (1024 by default) zeroes both memories; busy stays high meanwhile.
// The result strobe comes in the cycle after the row update, in which busy drops again.
`include "set_assoc_lru_cache_model_macros.svh"
module set_assoc_lru_cache_model import salc_pkg::*; #(
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  action_t          action,
	input  logic [31:0]      address,
	output logic             done,
	output logic             hit,
	output logic             side,
	output logic [31:0]      access_count,
	output logic [31:0]      miss_count,
	output logic [31:0]      replace_count,
	output logic [31:0]      fetch_words,
	output logic [31:0]      copyback_words,
	input  logic             wr_en,
	input  cfg_idx_t         wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	localparam int SL_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int NROWS  = 1 << SL_MAX;
	localparam int IW     = (SL_MAX > 0) ? SL_MAX : 1;
	localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [WW-1:0] RANK_TOP = WW'(MAX_WAYS - 1);
	localparam logic [4:0]    SL_CAP   = 5'(SL_MAX);
	localparam logic [4:0]    NW_CAP   = 5'(MAX_WAYS);
	localparam logic [IW-1:0] LAST_ROW = IW'(NROWS - 1);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_FDONE = 3'd4;

	typedef struct packed {
		logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
		logic [MAX_WAYS-1:0]                valid;
		logic [MAX_WAYS-1:0]                dirty;
		logic [MAX_WAYS-1:0][WW-1:0]        rank;
	} row_t;

	// configuration
	logic       split_q, wb_q, wa_q;
	logic [3:0] dsl_q, isl_q, ways_q, boff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 1'b1;
			dsl_q   <= 4'd6;
			isl_q   <= 4'd6;
			ways_q  <= 4'd1;
			boff_q  <= 4'd4;
			wb_q    <= 1'b0;
			wa_q    <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SPLIT: split_q <= wr_data[0];
				CFG_DSETS: dsl_q   <= wr_data;
				CFG_ISETS: isl_q   <= wr_data;
				CFG_WAYS:  ways_q  <= wr_data;
				CFG_BOFF:  boff_q  <= wr_data;
				CFG_WB:    wb_q    <= wr_data[0];
				CFG_WA:    wa_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [3:0]           off, wsh;
	logic [4:0]           nw, dsl, isl;
	logic [31:0]          words;
	logic [ADDR_BITS-1:0] a_in;
	logic [IW-1:0]        didx, iidx;
	logic [ADDR_BITS-1:0] dtag, itag;

	always_comb begin
		if (boff_q < BOFF_MIN)      off = BOFF_MIN;
		else if (boff_q > BOFF_MAX) off = BOFF_MAX;
		else                        off = boff_q;
		wsh   = off - BOFF_MIN;
		words = 32'd1 << wsh;
		if (ways_q == 4'd0)               nw = 5'd1;
		else if ({1'b0, ways_q} > NW_CAP) nw = NW_CAP;
		else                              nw = {1'b0, ways_q};
		dsl  = ({1'b0, dsl_q} > SL_CAP) ? SL_CAP : {1'b0, dsl_q};
		isl  = ({1'b0, isl_q} > SL_CAP) ? SL_CAP : {1'b0, isl_q};
		a_in = ADDR_BITS'(address);
		didx = IW'((a_in >> off) & ((ADDR_BITS'(1) << dsl) - ADDR_BITS'(1)));
		iidx = IW'((a_in >> off) & ((ADDR_BITS'(1) << isl) - ADDR_BITS'(1)));
		dtag = a_in >> ({2'b00, off} + {1'b0, dsl});
		itag = a_in >> ({2'b00, off} + {1'b0, isl});
	end

	// control state
	logic [2:0]           state_q;
	logic [IW-1:0]        cnt_row_q;
	logic                 fl_v_s1;
	logic [IW-1:0]        fl_row_s1;
	action_t              act_s1;
	logic                 ins_s1;
	logic [IW-1:0]        set_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic                 accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// memories
	row_t          dmem [NROWS];
	row_t          imem [NROWS];
	row_t          drow_s1, irow_s1, dwd, iwd;
	logic          dwe, iwe;
	logic [IW-1:0] dra, dwa, iwa;
	row_t          nrow, frow;

	always_ff @(posedge clk) begin
		if (dwe) dmem[dwa] <= dwd;
		drow_s1 <= dmem[dra];
	end

	always_ff @(posedge clk) begin
		if (iwe) imem[iwa] <= iwd;
		irow_s1 <= imem[iidx];
	end

	// lookup and row update
	row_t          r;
	logic          hit_d, free_d, alloc, wr_s1, age_all;
	logic [WW-1:0] hw, fw, vw, w, old_rank;
	logic [MAX_WAYS-1:0] dv;
	logic [4:0]    ndirty;

	always_comb begin
		r       = ins_s1 ? irow_s1 : drow_s1;
		wr_s1   = (act_s1 == ACT_WRITE);
		alloc   = !wr_s1 || wa_q;
		hit_d   = 1'b0;
		free_d  = 1'b0;
		hw      = '0;
		fw      = '0;
		vw      = '0;
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (5'(k) < nw && r.valid[k] && r.tag[k] == tag_s1) begin
				hit_d = 1'b1;
				hw    = WW'(k);
			end
			if (5'(k) < nw && !r.valid[k]) begin
				free_d = 1'b1;
				fw     = WW'(k);
			end
		end
		for (int k = 1; k < MAX_WAYS; k++) begin
			if (5'(k) < nw && r.rank[k] > r.rank[vw]) vw = WW'(k);
		end
		w        = hit_d ? hw : (free_d ? fw : vw);
		age_all  = !hit_d && free_d;
		old_rank = r.rank[w];
		nrow     = r;
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (5'(k) < nw && WW'(k) != w && r.valid[k] &&
			    (age_all || r.rank[k] < old_rank) && r.rank[k] < RANK_TOP)
				nrow.rank[k] = r.rank[k] + WW'(1);
		end
		nrow.rank[w] = '0;
		if (hit_d) begin
			nrow.dirty[w] = r.dirty[w] | wr_s1;
		end else begin
			nrow.valid[w] = 1'b1;
			nrow.tag[w]   = tag_s1;
			nrow.dirty[w] = wr_s1;
		end
		// flush row: drop valid and dirty, count dirty lines
		frow       = drow_s1;
		frow.valid = '0;
		frow.dirty = '0;
		dv         = drow_s1.valid & drow_s1.dirty;
		ndirty     = 5'($countones(dv));
	end

	// memory ports
	always_comb begin
		dra = didx;
		dwe = 1'b0;
		dwa = set_s1;
		dwd = nrow;
		iwe = 1'b0;
		iwa = set_s1;
		iwd = nrow;
		unique case (state_q)
			ST_CLR: begin
				dwe = 1'b1;
				dwa = cnt_row_q;
				dwd = '0;
				iwe = 1'b1;
				iwa = cnt_row_q;
				iwd = '0;
			end
			ST_LOOK: begin
				dwe = !ins_s1 && (hit_d || alloc);
				iwe = ins_s1;
			end
			ST_FLUSH, ST_FDONE: begin
				dra = cnt_row_q;
				dwe = fl_v_s1;
				dwa = fl_row_s1;
				dwd = frow;
			end
			default: ;
		endcase
	end

	// statistics counters
	logic [31:0] acc_q [2];
	logic [31:0] miss_q [2];
	logic [31:0] repl_q [2];
	logic [31:0] fetch_q [2];
	logic [31:0] copy_q;
	logic [31:0] acc_d [2];
	logic [31:0] miss_d [2];
	logic [31:0] repl_d [2];
	logic [31:0] fetch_d [2];
	logic [31:0] copy_d;
	logic        sd;

	always_comb begin
		acc_d   = acc_q;
		miss_d  = miss_q;
		repl_d  = repl_q;
		fetch_d = fetch_q;
		copy_d  = copy_q;
		sd      = (act_s1 == ACT_FETCH);
		if (state_q == ST_LOOK) begin
			acc_d[sd] = acc_q[sd] + 32'd1;
			if (!hit_d) begin
				miss_d[sd] = miss_q[sd] + 32'd1;
				if (alloc) begin
					fetch_d[sd] = fetch_q[sd] + words;
					if (!free_d) begin
						repl_d[sd] = repl_q[sd] + 32'd1;
						if (wb_q && r.dirty[vw]) copy_d = copy_d + words;
					end
				end
			end
			if (wr_s1 && (!wb_q || (!hit_d && !wa_q))) copy_d = copy_d + 32'd1;
		end
		if (fl_v_s1 && wb_q) copy_d = copy_q + ({27'd0, ndirty} << wsh);
	end

	// sequencer, counters and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			cnt_row_q <= '0;
			fl_v_s1   <= 1'b0;
			done      <= 1'b0;
			acc_q     <= '{default: '0};
			miss_q    <= '{default: '0};
			repl_q    <= '{default: '0};
			fetch_q   <= '{default: '0};
			copy_q    <= '0;
		end else begin
			acc_q   <= acc_d;
			miss_q  <= miss_d;
			repl_q  <= repl_d;
			fetch_q <= fetch_d;
			copy_q  <= copy_d;
			done    <= 1'b0;
			fl_v_s1 <= (state_q == ST_FLUSH);
			unique case (state_q)
				ST_CLR: begin
					cnt_row_q <= cnt_row_q + IW'(1);
					if (cnt_row_q == LAST_ROW) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					cnt_row_q <= '0;
					if (accept) state_q <= (action == ACT_FLUSH) ? ST_FLUSH : ST_LOOK;
				end
				ST_LOOK: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					cnt_row_q <= cnt_row_q + IW'(1);
					if (cnt_row_q == LAST_ROW) state_q <= ST_FDONE;
				end
				ST_FDONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture command and result payload
	always_ff @(posedge clk) begin
		fl_row_s1 <= cnt_row_q;
		if (accept) begin
			act_s1 <= action;
			ins_s1 <= (action == ACT_FETCH) && split_q;
			set_s1 <= ((action == ACT_FETCH) && split_q) ? iidx : didx;
			tag_s1 <= ((action == ACT_FETCH) && split_q) ? itag : dtag;
		end
		if (state_q == ST_LOOK || state_q == ST_FDONE) begin
			hit            <= (state_q == ST_LOOK) && hit_d;
			side           <= (state_q == ST_LOOK) && sd;
			access_count   <= (state_q == ST_LOOK) ? acc_d[sd]   : acc_d[0];
			miss_count     <= (state_q == ST_LOOK) ? miss_d[sd]  : miss_d[0];
			replace_count  <= (state_q == ST_LOOK) ? repl_d[sd]  : repl_d[0];
			fetch_words    <= (state_q == ST_LOOK) ? fetch_d[sd] : fetch_d[0];
			copyback_words <= copy_d;
		end
	end

	`SALC_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`SALC_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SALC_ASSERT_IMP(a_done_after_work, clk, arst_n, done, $past(busy))

endmodule

### tb/sv/set_assoc_lru_cache_model_tb.sv
`timescale 1ns / 1ps
module set_assoc_lru_cache_model_tb import salc_pkg::*; ();

	localparam int NSETS = 1024;
	localparam int NWAYS = 8;
	localparam int NLINES = NSETS * NWAYS;

	typedef struct packed {
		logic        hit;
		logic        side;
		logic [31:0] acc;
		logic [31:0] miss;
		logic [31:0] repl;
		logic [31:0] fetch;
		logic [31:0] copyb;
	} cache_stat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	action_t action = ACT_READ;
	logic [31:0] address = '0;
	logic done, hit, side;
	logic [31:0] access_count, miss_count, replace_count, fetch_words, copyback_words;
	logic wr_en = 1'b0;
	cfg_idx_t wr_index = CFG_SPLIT;
	logic [CFG_W-1:0] wr_data = '0;

	set_assoc_lru_cache_model uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow cache state
	logic [31:0] d_tag [NLINES];
	logic        d_val [NLINES];
	logic        d_dty [NLINES];
	logic [2:0]  d_rnk [NLINES];
	logic [31:0] i_tag [NLINES];
	logic        i_val [NLINES];
	logic [2:0]  i_rnk [NLINES];
	logic [31:0] stat_cnt [10];
	logic [3:0]  reg_file [7];

	cache_stat_t pending_stats [$];
	int errors = 0;
	bit idle_ok = 1'b1;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// LRU update: promote way w, age younger valid lines
	function automatic void promote(bit is_i, int base, int nw, int w, int old);
		for (int k = 0; k < nw; k++) begin
			int j;
			j = base + k;
			if (is_i) begin
				if (k != w && i_val[j] && i_rnk[j] < old && i_rnk[j] < NWAYS - 1) i_rnk[j]++;
			end else begin
				if (k != w && d_val[j] && d_rnk[j] < old && d_rnk[j] < NWAYS - 1) d_rnk[j]++;
			end
		end
		if (is_i) i_rnk[base + w] = 0;
		else d_rnk[base + w] = 0;
	endfunction

	function automatic bit lookup_line(bit is_i, int sl_in, logic [31:0] a, bit wr, bit alloc,
		int sd);
		int sl, off, nw, set_idx, base, w, best;
		logic [31:0] tg;
		logic [31:0] words;
		sl = (sl_in > 10) ? 10 : sl_in;
		off = reg_file[CFG_BOFF] < 2 ? 2 : (reg_file[CFG_BOFF] > 12 ? 12 : reg_file[CFG_BOFF]);
		nw = reg_file[CFG_WAYS] < 1 ? 1 : (reg_file[CFG_WAYS] > NWAYS ? NWAYS : reg_file[CFG_WAYS]);
		set_idx = (a >> off) & ((1 << sl) - 1);
		tg = 32'(64'(a) >> (off + sl));
		base = set_idx * NWAYS;
		words = 32'd1 << (off - 2);
		for (int k = 0; k < nw; k++) begin
			int j;
			j = base + k;
			if (is_i ? (i_val[j] && i_tag[j] == tg) : (d_val[j] && d_tag[j] == tg)) begin
				promote(is_i, base, nw, k, is_i ? i_rnk[j] : d_rnk[j]);
				if (wr) d_dty[j] = 1'b1;
				return 1'b1;
			end
		end
		stat_cnt[sd * 5 + 1]++;
		if (!alloc) return 1'b0;
		w = nw;
		for (int k = 0; k < nw; k++)
			if (!(is_i ? i_val[base + k] : d_val[base + k])) begin
				w = k;
				break;
			end
		if (w < nw) begin
			promote(is_i, base, nw, w, 255);
		end else begin
			best = 0;
			for (int k = 1; k < nw; k++)
				if ((is_i ? i_rnk[base + k] : d_rnk[base + k]) >
				    (is_i ? i_rnk[base + best] : d_rnk[base + best])) best = k;
			w = best;
			if (!is_i && reg_file[CFG_WB][0] && d_dty[base + w]) stat_cnt[4] += words;
			stat_cnt[sd * 5 + 2]++;
			promote(is_i, base, nw, w, is_i ? i_rnk[base + w] : d_rnk[base + w]);
		end
		if (is_i) begin
			i_val[base + w] = 1'b1;
			i_tag[base + w] = tg;
		end else begin
			d_val[base + w] = 1'b1;
			d_tag[base + w] = tg;
			d_dty[base + w] = wr;
		end
		return 1'b0;
	endfunction

	function automatic cache_stat_t predict_access(action_t act, logic [31:0] a);
		cache_stat_t r;
		int off;
		logic [31:0] words;
		bit h, sd;
		off = reg_file[CFG_BOFF] < 2 ? 2 : (reg_file[CFG_BOFF] > 12 ? 12 : reg_file[CFG_BOFF]);
		words = 32'd1 << (off - 2);
		h = 0;
		sd = 0;
		if (act == ACT_FLUSH) begin
			for (int j = 0; j < NLINES; j++) begin
				if (d_val[j] && d_dty[j] && reg_file[CFG_WB][0]) stat_cnt[4] += words;
				d_val[j] = 1'b0;
				d_dty[j] = 1'b0;
			end
		end else if (act == ACT_FETCH) begin
			sd = 1;
			if (reg_file[CFG_SPLIT][0]) h = lookup_line(1, reg_file[CFG_ISETS], a, 0, 1, 1);
			else h = lookup_line(0, reg_file[CFG_DSETS], a, 0, 1, 1);
			stat_cnt[5]++;
			if (!h) stat_cnt[8] += words;
		end else begin
			bit wr, alloc;
			wr = (act == ACT_WRITE);
			alloc = !wr || reg_file[CFG_WA][0];
			h = lookup_line(0, reg_file[CFG_DSETS], a, wr, alloc, 0);
			stat_cnt[0]++;
			if (!h && alloc) stat_cnt[3] += words;
			if (wr) begin
				if (!reg_file[CFG_WB][0]) stat_cnt[4] += 1;
				else if (!h && !reg_file[CFG_WA][0]) stat_cnt[4] += 1;
			end
		end
		r.hit = h;
		r.side = sd;
		r.acc = stat_cnt[sd * 5];
		r.miss = stat_cnt[sd * 5 + 1];
		r.repl = stat_cnt[sd * 5 + 2];
		r.fetch = stat_cnt[sd * 5 + 3];
		r.copyb = stat_cnt[4];
		return r;
	endfunction

	// check every result transfer against the oldest expectation
	always @(posedge clk) begin
		if (done) begin
			if (pending_stats.size() == 0) begin
				$display("MISMATCH unexpected result at %0t", $realtime);
				errors++;
			end else begin
				cache_stat_t e;
				e = pending_stats.pop_front();
				if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
				if (side !== e.side) report_mismatch("side", side, e.side);
				if (access_count !== e.acc) report_mismatch("access_count", access_count, e.acc);
				if (miss_count !== e.miss) report_mismatch("miss_count", miss_count, e.miss);
				if (replace_count !== e.repl) report_mismatch("replace_count", replace_count, e.repl);
				if (fetch_words !== e.fetch) report_mismatch("fetch_words", fetch_words, e.fetch);
				if (copyback_words !== e.copyb)
					report_mismatch("copyback_words", copyback_words, e.copyb);
			end
		end
	end

	// send one command; hold start until the transfer, then let busy settle
	task automatic send_cmd(action_t act, logic [31:0] a);
		if (!idle_ok) begin
		end else begin
			while ($urandom_range(99) < 19) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		address <= a;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_stats.push_back(predict_access(act, a));
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [3:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			CFG_SPLIT, CFG_WB, CFG_WA: reg_file[idx] = {3'b0, val[0]};
			default: reg_file[idx] = val;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(bit sp, logic [3:0] ds, logic [3:0] is, logic [3:0] wy,
		logic [3:0] bo, bit wb, bit wa);
		drain();
		write_reg(CFG_SPLIT, {3'b0, sp});
		write_reg(CFG_DSETS, ds);
		write_reg(CFG_ISETS, is);
		write_reg(CFG_WAYS, wy);
		write_reg(CFG_BOFF, bo);
		write_reg(CFG_WB, {3'b0, wb});
		write_reg(CFG_WA, {3'b0, wa});
	endtask

	// address drawn from a small tag pool so sets conflict and hit
	function automatic logic [31:0] pool_addr();
		logic [31:0] a;
		a = $urandom();
		if ($urandom_range(3) != 0) a = a & 32'h0000_7c3c;
		if ($urandom_range(7) == 0) a = a | 32'hffff_0000;
		return a;
	endfunction

	function automatic action_t pick_act();
		int r;
		r = $urandom_range(99);
		if (r < 40) return ACT_READ;
		if (r < 72) return ACT_WRITE;
		if (r < 97) return ACT_FETCH;
		return ACT_FLUSH;
	endfunction

	task automatic test_directed();
		send_cmd(ACT_READ, 32'h0000_0000);
		send_cmd(ACT_READ, 32'h0000_0000);
		send_cmd(ACT_WRITE, 32'hffff_ffff);
		send_cmd(ACT_WRITE, 32'hffff_ffff);
		send_cmd(ACT_FETCH, 32'h0000_0000);
		send_cmd(ACT_FETCH, 32'hffff_fffc);
		send_cmd(ACT_READ, 32'h0000_0400);
		send_cmd(ACT_FLUSH, 32'h1234_5678);
		send_cmd(ACT_READ, 32'h0000_0000);
		set_config(0, 4'd0, 4'd15, 4'd0, 4'd0, 1, 0);
		send_cmd(ACT_WRITE, 32'h0000_0010);
		send_cmd(ACT_READ, 32'h0000_0010);
		send_cmd(ACT_WRITE, 32'h0000_0010);
		send_cmd(ACT_READ, 32'h0000_0020);
		send_cmd(ACT_FETCH, 32'h0000_0030);
		send_cmd(ACT_FLUSH, 32'h0);
		set_config(1, 4'd15, 4'd10, 4'd15, 4'd15, 1, 1);
		for (int k = 0; k < 9; k++) send_cmd(ACT_WRITE, 32'(k) << 22);
		send_cmd(ACT_FLUSH, 32'h0);
	endtask

	task automatic test_random(int n);
		for (int k = 0; k < n; k++) begin
			idle_ok = !(k >= n / 3 && k < n / 2);
			send_cmd(pick_act(), pool_addr());
			if (k == n / 4) drain();
		end
		idle_ok = 1'b1;
	endtask

	initial begin
		foreach (reg_file[i]) reg_file[i] = '0;
		reg_file[CFG_SPLIT] = 1;
		reg_file[CFG_DSETS] = 6;
		reg_file[CFG_ISETS] = 6;
		reg_file[CFG_WAYS] = 1;
		reg_file[CFG_BOFF] = 4;
		reg_file[CFG_WA] = 1;
		foreach (stat_cnt[i]) stat_cnt[i] = '0;
		for (int j = 0; j < NLINES; j++) begin
			d_val[j] = 0; d_dty[j] = 0; d_rnk[j] = 0; d_tag[j] = 0;
			i_val[j] = 0; i_rnk[j] = 0; i_tag[j] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_config(1, 4'd2, 4'd1, 4'd4, 4'd4, 1, 1);
		test_random(260);
		set_config(0, 4'd3, 4'd0, 4'd8, 4'd2, 0, 0);
		test_random(260);
		set_config(1, 4'd1, 4'd3, 4'd2, 4'd12, 0, 1);
		test_random(260);
		set_config(0, 4'd10, 4'd10, 4'd3, 4'd5, 1, 0);
		test_random(260);
		drain();
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
